// File: hdl/lss_pkg.sv
`timescale 1ns / 1ps

package lss_pkg;

  // Request kinds carried on the input side.
  typedef logic [1:0] req_t;
  localparam req_t REQ_PUSH   = 2'd0;
  localparam req_t REQ_POP    = 2'd1;
  localparam req_t REQ_SEARCH = 2'd2;
  localparam req_t REQ_GET    = 2'd3;

  // Result status codes.
  typedef logic [2:0] status_t;
  localparam status_t ST_OK       = 3'd0;
  localparam status_t ST_EMPTY    = 3'd1;
  localparam status_t ST_NOTFOUND = 3'd2;
  localparam status_t ST_RANGE    = 3'd3;
  localparam status_t ST_FULL     = 3'd4;

  // Read address selection.
  typedef logic [1:0] rd_sel_t;
  localparam rd_sel_t SEL_TOP  = 2'd0;
  localparam rd_sel_t SEL_POS  = 2'd1;
  localparam rd_sel_t SEL_SCAN = 2'd2;

  // Fixed field widths.
  localparam int POS_W   = 6;
  localparam int COUNT_W = 7;
  localparam int WORD_W  = 32;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    load;
    logic    push;
    logic    pop;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    scan_next;
    logic    cap_data;
    logic    cap_found;
    logic    set_status;
    status_t status;
    logic    emit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    req_t req_type;
    logic empty;
    logic full;
    logic range_err;
    logic match;
    logic scan_last;
    logic out_free;
  } stat_t;

endpackage

// File: hdl/lss_ctrl.sv
`timescale 1ns / 1ps

module lss_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  lss_pkg::stat_t stat,
  output lss_pkg::cmd_t  cmd
);
  import lss_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_WAIT = 3'd2;
  localparam logic [2:0] S_SCAN = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    in_ready   = 1'b0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.set_status = 1'b1;
        cmd.status     = ST_OK;
        unique case (stat.req_type)
          REQ_PUSH: begin
            if (stat.full) begin
              cmd.status = ST_FULL;
            end else begin
              cmd.push = 1'b1;
            end
            state_next = S_OUT;
          end
          REQ_POP: begin
            if (stat.empty) begin
              cmd.status = ST_EMPTY;
              state_next = S_OUT;
            end else begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = SEL_TOP;
              cmd.pop    = 1'b1;
              state_next = S_WAIT;
            end
          end
          REQ_SEARCH: begin
            if (stat.empty) begin
              cmd.status = ST_EMPTY;
              state_next = S_OUT;
            end else begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = SEL_TOP;
              state_next = S_SCAN;
            end
          end
          REQ_GET: begin
            if (stat.empty) begin
              cmd.status = ST_EMPTY;
              state_next = S_OUT;
            end else if (stat.range_err) begin
              cmd.status = ST_RANGE;
              state_next = S_OUT;
            end else begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = SEL_POS;
              state_next = S_WAIT;
            end
          end
          default: state_next = S_OUT;
        endcase
      end
      S_WAIT: begin
        cmd.cap_data = 1'b1;
        state_next   = S_OUT;
      end
      S_SCAN: begin
        if (stat.match) begin
          cmd.set_status = 1'b1;
          cmd.status     = ST_OK;
          cmd.cap_found  = 1'b1;
          state_next     = S_OUT;
        end else if (stat.scan_last) begin
          cmd.set_status = 1'b1;
          cmd.status     = ST_NOTFOUND;
          state_next     = S_OUT;
        end else begin
          cmd.scan_next = 1'b1;
          cmd.rd_en     = 1'b1;
          cmd.rd_sel    = SEL_SCAN;
        end
      end
      S_OUT: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// File: hdl/lss_datapath.sv
`timescale 1ns / 1ps

module lss_datapath #(
  parameter int DEPTH = 64
) (
  input  logic                               clk,
  input  logic                               rst,
  input  lss_pkg::cmd_t                      cmd,
  output lss_pkg::stat_t                     stat,
  input  lss_pkg::req_t                      in_req_type,
  input  logic signed [lss_pkg::WORD_W-1:0]  in_value,
  input  logic [lss_pkg::POS_W-1:0]          in_position,
  output logic                               out_valid,
  input  logic                               out_ready,
  output lss_pkg::status_t                   out_status,
  output logic signed [lss_pkg::WORD_W-1:0]  out_data,
  output logic [lss_pkg::POS_W-1:0]          out_found,
  output logic [lss_pkg::COUNT_W-1:0]        out_count,
  output logic                               out_empty
);
  import lss_pkg::*;

  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int CMP_W = (CW > POS_W) ? CW : POS_W;

  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rd_data;

  logic [CW-1:0]     cnt;
  req_t              req_type;
  logic [WORD_W-1:0] value;
  logic [POS_W-1:0]  pos;
  logic [AW-1:0]     scan_idx;
  status_t           res_status;
  logic [WORD_W-1:0] res_data;
  logic [POS_W-1:0]  res_found;

  logic [CMP_W-1:0]  offset;
  logic [CMP_W-1:0]  addr_wide;
  logic [AW-1:0]     rd_addr;

  // Read address counted down from the top of the stack.
  always_comb begin
    case (cmd.rd_sel)
      SEL_POS:  offset = CMP_W'(pos);
      SEL_SCAN: offset = CMP_W'(scan_idx) + CMP_W'(1);
      default:  offset = '0;
    endcase
    addr_wide = CMP_W'(cnt) - CMP_W'(1) - offset;
    rd_addr   = addr_wide[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[cnt[AW-1:0]] <= value;
    end
    if (cmd.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.push) begin
      cnt <= cnt + CW'(1);
    end else if (cmd.pop) begin
      cnt <= cnt - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_type  <= in_req_type;
      value     <= in_value;
      pos       <= in_position;
      scan_idx  <= '0;
      res_data  <= '0;
      res_found <= '0;
    end
    if (cmd.scan_next) begin
      scan_idx <= scan_idx + AW'(1);
    end
    if (cmd.set_status) begin
      res_status <= cmd.status;
    end
    if (cmd.cap_data) begin
      res_data <= rd_data;
    end
    if (cmd.cap_found) begin
      res_found <= POS_W'(scan_idx);
    end
  end

  // Output register: a finished result waits here until it is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_status <= res_status;
      out_data   <= res_data;
      out_found  <= res_found;
      out_count  <= COUNT_W'(cnt);
      out_empty  <= (cnt == '0);
    end
  end

  always_comb begin
    stat.req_type  = req_type;
    stat.empty     = (cnt == '0);
    stat.full      = (cnt == CW'(DEPTH));
    stat.range_err = (CMP_W'(pos) >= CMP_W'(cnt));
    stat.match     = (rd_data == value);
    stat.scan_last = ((CW'(scan_idx) + CW'(1)) == cnt);
    stat.out_free  = !out_valid || out_ready;
  end

endmodule

// File: hdl/lifo_stack_with_search.sv
`timescale 1ns / 1ps
// Push and refused requests pass through decode to the output register; pop
// and get add a memory read before it, and a search reads the words from the
// top down until a match or the last stored word (up to DEPTH words). One
// request is handled at a time; a result waits while the output register is full.
// Synchronous active-high reset empties the stack; stored words are not cleared.

module lifo_stack_with_search #(
  parameter int DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // value[31:0], position[37:32], zero pad[39:38]
  input  logic [1:0]  s_tuser,   // req_type[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // data_out[31:0], found_index[37:32], count[44:38],
                                 // is_empty[45], zero pad[47:46]
  output logic [2:0]  m_tuser    // status[2:0]
);
  import lss_pkg::*;

  // The controller steps through decode, memory read and the top-down search
  // walk; the datapath holds the stack memory, the fill count, the captured
  // request and the output register that parts the two sides.
  cmd_t  cmd;
  stat_t stat;

  status_t                   out_status;
  logic signed [WORD_W-1:0]  out_data;
  logic [POS_W-1:0]          out_found;
  logic [COUNT_W-1:0]        out_count;
  logic                      out_empty;

  lss_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  lss_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .in_req_type (s_tuser),
    .in_value    (s_tdata[31:0]),
    .in_position (s_tdata[37:32]),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_status  (out_status),
    .out_data    (out_data),
    .out_found   (out_found),
    .out_count   (out_count),
    .out_empty   (out_empty)
  );

  // Result fields are packed from the lowest bit up, with the pad held at zero.
  assign m_tdata = {2'b00, out_empty, out_count, out_found, out_data};
  assign m_tuser = out_status;

endmodule
